// File: design/alu8080_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8080_pkg
// Operation codes, field widths and helpers for the 8080 ALU with flags.
// ----------------------------------------------------------------------------
package alu8080_pkg;

  localparam int MODE_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // operation codes
  localparam logic [MODE_W-1:0] OP_ADD = 4'd0;
  localparam logic [MODE_W-1:0] OP_ADC = 4'd1;
  localparam logic [MODE_W-1:0] OP_SUB = 4'd2;
  localparam logic [MODE_W-1:0] OP_SBB = 4'd3;
  localparam logic [MODE_W-1:0] OP_ANA = 4'd4;
  localparam logic [MODE_W-1:0] OP_XRA = 4'd5;
  localparam logic [MODE_W-1:0] OP_ORA = 4'd6;
  localparam logic [MODE_W-1:0] OP_CMP = 4'd7;
  localparam logic [MODE_W-1:0] OP_INR = 4'd8;
  localparam logic [MODE_W-1:0] OP_DCR = 4'd9;
  localparam logic [MODE_W-1:0] OP_RLC = 4'd10;
  localparam logic [MODE_W-1:0] OP_RRC = 4'd11;
  localparam logic [MODE_W-1:0] OP_RAR = 4'd12;
  localparam logic [MODE_W-1:0] OP_CMA = 4'd13;
  localparam logic [MODE_W-1:0] OP_STC = 4'd14;

  // the five condition flags
  typedef struct packed {
    logic aux;
    logic parity;
    logic sign;
    logic zero;
    logic carry;
  } flags_t;

  // one for even parity of the byte
  function automatic logic even_parity(input logic [BYTE_W-1:0] v);
    return ~(^v);
  endfunction

endpackage

// File: design/cpu8080_alu_with_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8080_alu_with_flags
// 8080 ALU: arithmetic, logical, rotate, complement and set-carry operations
// on a byte with the five condition flags, one item per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser
// s_*     | in  | acc_in, operand, carry, zero, sign,     | mode
//         |     | parity, aux                             |
// m_*     | out | result, carry, zero, sign, parity, aux  | -
//
// An item is registered on acceptance, worked out in the next stage and held
// in the result register; one item per cycle unless m_tready stalls the output.
// rst clears both stage valid bits; payload registers are not reset.
// A stall on m_tready holds the result register and then the input register;
// s_tready drops only when both are full and the output is stalled.
// ----------------------------------------------------------------------------
module cpu8080_alu_with_flags (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // acc_in[7:0], operand[15:8], carry_in[16], zero_in[17], sign_in[18],
  // parity_in[19], aux_in[20], zero pad[23:21]
  input  logic [alu8080_pkg::IN_TDATA_W-1:0]   s_tdata,
  // mode[3:0]
  input  logic [alu8080_pkg::MODE_W-1:0]       s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // result[7:0], carry_out[8], zero_out[9], sign_out[10], parity_out[11],
  // aux_out[12], zero pad[15:13]
  output logic [alu8080_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import alu8080_pkg::*;

  // input stage
  logic              in_valid;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] acc;
  logic [BYTE_W-1:0] opnd;
  flags_t            flags;

  // result stage
  logic              out_valid;
  logic [BYTE_W-1:0] res;
  flags_t            res_flags;

  logic              out_free;
  logic              advance;

  // datapath nets
  logic              sub_op;
  logic              cin;
  logic [BYTE_W-1:0] b_eff;
  logic [BYTE_W:0]   sum;
  logic [NIB_W:0]    nib_sum;
  logic [BYTE_W-1:0] inc_val;
  logic [BYTE_W-1:0] dec_val;
  logic [BYTE_W-1:0] res_next;
  flags_t            flags_next;

  // handshake
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, res_flags.aux, res_flags.parity, res_flags.sign,
                     res_flags.zero, res_flags.carry, res};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      acc          <= s_tdata[7:0];
      opnd         <= s_tdata[15:8];
      flags.carry  <= s_tdata[16];
      flags.zero   <= s_tdata[17];
      flags.sign   <= s_tdata[18];
      flags.parity <= s_tdata[19];
      flags.aux    <= s_tdata[20];
      mode         <= s_tuser;
    end
  end

  // shared adder: subtraction adds the complement with inverted borrow
  assign sub_op  = (mode == OP_SUB) || (mode == OP_SBB) || (mode == OP_CMP);
  assign b_eff   = sub_op ? ~opnd : opnd;
  assign cin     = ((mode == OP_ADC) || (mode == OP_SBB)) ? (flags.carry ^ sub_op)
                                                          : sub_op;
  assign sum     = {1'b0, acc} + {1'b0, b_eff} + {{BYTE_W{1'b0}}, cin};
  assign nib_sum = {1'b0, acc[NIB_W-1:0]} + {1'b0, b_eff[NIB_W-1:0]}
                 + {{NIB_W{1'b0}}, cin};
  assign inc_val = acc + 8'd1;
  assign dec_val = acc - 8'd1;

  // operation select and flag update
  always_comb begin
    res_next   = acc;
    flags_next = flags;
    unique case (mode)
      OP_ADD, OP_ADC: begin
        res_next         = sum[BYTE_W-1:0];
        flags_next.carry = sum[BYTE_W];
        flags_next.aux   = nib_sum[NIB_W];
      end
      OP_SUB, OP_SBB, OP_CMP: begin
        res_next         = (mode == OP_CMP) ? acc : sum[BYTE_W-1:0];
        flags_next.carry = ~sum[BYTE_W];
        flags_next.aux   = nib_sum[NIB_W];
      end
      OP_ANA, OP_XRA, OP_ORA: begin
        res_next         = (mode == OP_ANA) ? (acc & opnd)
                         : (mode == OP_XRA) ? (acc ^ opnd) : (acc | opnd);
        flags_next.carry = 1'b0;
        flags_next.aux   = 1'b0;
      end
      OP_INR: begin
        res_next       = inc_val;
        flags_next.aux = (acc[NIB_W-1:0] == 4'hf);
      end
      OP_DCR: begin
        res_next       = dec_val;
        flags_next.aux = (acc[NIB_W-1:0] != 4'h0);
      end
      OP_RLC: begin
        res_next         = {acc[6:0], acc[7]};
        flags_next.carry = acc[7];
      end
      OP_RRC: begin
        res_next         = {acc[0], acc[7:1]};
        flags_next.carry = acc[0];
      end
      OP_RAR: begin
        res_next         = {flags.carry, acc[7:1]};
        flags_next.carry = acc[0];
      end
      OP_CMA: begin
        res_next = ~acc;
      end
      OP_STC: begin
        flags_next.carry = 1'b1;
      end
      default: begin
        // unused code: pass everything through
        res_next   = acc;
        flags_next = flags;
      end
    endcase
    // zero, sign and parity follow the adder or the result byte; other modes keep them
    if (sub_op) begin
      flags_next.zero   = (sum[BYTE_W-1:0] == 8'h00);
      flags_next.sign   = sum[BYTE_W-1];
      flags_next.parity = even_parity(sum[BYTE_W-1:0]);
    end else if ((mode == OP_ADD) || (mode == OP_ADC) || (mode == OP_ANA) ||
                 (mode == OP_XRA) || (mode == OP_ORA) || (mode == OP_INR) ||
                 (mode == OP_DCR)) begin
      flags_next.zero   = (res_next == 8'h00);
      flags_next.sign   = res_next[BYTE_W-1];
      flags_next.parity = even_parity(res_next);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      res       <= res_next;
      res_flags <= flags_next;
    end
  end

endmodule
